// ===== design/mtt_pkg.sv =====
package mtt_pkg;

  // table size and derived widths
  localparam int MAX_MARKERS = 16;
  localparam int CNT_W       = $clog2(MAX_MARKERS + 1);
  localparam int ID_W        = 16;
  localparam int CTR_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // command codes
  localparam logic [2:0] CMD_BEGIN  = 3'd0;
  localparam logic [2:0] CMD_DETECT = 3'd1;
  localparam logic [2:0] CMD_END    = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_FORGET = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TOL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST  = 1'd1;

  localparam logic [CTR_W-1:0] LOST_TOL_RESET = 16'd30;

  // operation carried by the token through the cell row
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BEGIN,
    OP_DETECT,
    OP_END,
    OP_FIND,
    OP_FORGET,
    OP_CLEAR,
    OP_INSERT
  } cell_op_t;

  // token handed from cell to cell
  typedef struct packed {
    logic             valid;
    cell_op_t         op;
    logic [ID_W-1:0]  id;
    logic             hit;        // id matched in some cell
    logic             free_seen;  // some cell was empty
    logic             done;       // insert already taken
    logic             vis;
    logic [CTR_W-1:0] unseen;
    logic [CTR_W-1:0] followed;
    logic [CNT_W-1:0] count;      // valid entries after update
  } token_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    return (v != {CTR_W{1'b1}}) ? v + 1'b1 : v;
  endfunction

endpackage

// ===== design/marker_track_table.sv =====
// Channel   | handshake           | payload
// ----------+---------------------+--------------------------------------------
// in        | in_valid / in_stall | command, marker_id, pose_ok
// out       | out_valid/out_stall | status, found, visible_now, frames_unseen,
//           |                     | frames_followed, visible_total, entry_count
// cfg       | cfg_we              | cfg_index, cfg_data
//
// Each item runs one token along the row of MAX_MARKERS cells, one cell per
// cycle; a detection of a new id needs a second pass to claim the lowest
// empty cell.
// Synchronous reset empties the table and loads the register defaults.
// An item is taken while the previous result still waits; a stalled result
// holds the next one back in the hold state.
module marker_track_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       command,
  input  logic [mtt_pkg::ID_W-1:0]         marker_id,
  input  logic                             pose_ok,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic                             found,
  output logic                             visible_now,
  output logic [mtt_pkg::CTR_W-1:0]        frames_unseen,
  output logic [mtt_pkg::CTR_W-1:0]        frames_followed,
  output logic [mtt_pkg::CTR_W-1:0]        visible_total,
  output logic [mtt_pkg::CNT_W-1:0]        entry_count
);

  typedef enum logic [1:0] {S_IDLE, S_PASS1, S_PASS2, S_HOLD} state_t;

  state_t                      state;
  logic [mtt_pkg::CTR_W-1:0]   lost_tol;
  logic                        persist;
  logic [mtt_pkg::CTR_W-1:0]   vis_count;
  logic [mtt_pkg::ID_W-1:0]    id_r;
  mtt_pkg::token_t             tok_head;
  mtt_pkg::token_t             tok [mtt_pkg::MAX_MARKERS+1];
  mtt_pkg::token_t             tail;

  logic [1:0]                  res_status;
  logic                        res_found;
  logic                        res_vis;
  logic [mtt_pkg::CTR_W-1:0]   res_unseen;
  logic [mtt_pkg::CTR_W-1:0]   res_followed;
  logic [mtt_pkg::CNT_W-1:0]   res_count;

  function automatic mtt_pkg::cell_op_t op_of(input logic [2:0] cmd, input logic pose);
    mtt_pkg::cell_op_t op;
    op = mtt_pkg::OP_NONE;
    case (cmd)
      mtt_pkg::CMD_BEGIN:  op = mtt_pkg::OP_BEGIN;
      mtt_pkg::CMD_DETECT: op = pose ? mtt_pkg::OP_DETECT : mtt_pkg::OP_NONE;
      mtt_pkg::CMD_END:    op = mtt_pkg::OP_END;
      mtt_pkg::CMD_FIND:   op = mtt_pkg::OP_FIND;
      mtt_pkg::CMD_FORGET: op = mtt_pkg::OP_FORGET;
      mtt_pkg::CMD_CLEAR:  op = mtt_pkg::OP_CLEAR;
      default:             op = mtt_pkg::OP_NONE;
    endcase
    return op;
  endfunction

  function automatic mtt_pkg::token_t make_token(input mtt_pkg::cell_op_t op,
                                                 input logic [mtt_pkg::ID_W-1:0] id);
    mtt_pkg::token_t t;
    t           = '0;
    t.valid     = 1'b1;
    t.op        = op;
    t.id        = id;
    return t;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lost_tol <= mtt_pkg::LOST_TOL_RESET;
      persist  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtt_pkg::REG_LOST_TOL: lost_tol <= cfg_data;
        mtt_pkg::REG_PERSIST:  persist  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // row of cells
  assign tok[0] = tok_head;
  for (genvar i = 0; i < mtt_pkg::MAX_MARKERS; i++) begin : g_cell
    mtt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .lost_tol (lost_tol),
      .persist  (persist),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end
  assign tail = tok[mtt_pkg::MAX_MARKERS];

  assign in_stall = (state != S_IDLE);

  // sequencer, per-frame count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      tok_head.valid <= 1'b0;
      vis_count      <= '0;
    end else begin
      tok_head.valid <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            id_r     <= marker_id;
            tok_head <= make_token(op_of(command, pose_ok), marker_id);
            if (command == mtt_pkg::CMD_BEGIN) vis_count <= '0;
            state    <= S_PASS1;
          end
        end
        S_PASS1: begin
          if (tail.valid) begin
            res_status   <= mtt_pkg::STATUS_OK;
            res_found    <= 1'b0;
            res_vis      <= tail.vis;
            res_unseen   <= tail.unseen;
            res_followed <= tail.followed;
            res_count    <= tail.count;
            state        <= S_HOLD;
            if (tail.op == mtt_pkg::OP_DETECT) begin
              if (tail.hit) begin
                vis_count <= mtt_pkg::sat_inc(vis_count);
              end else if (tail.free_seen) begin
                tok_head <= make_token(mtt_pkg::OP_INSERT, id_r);
                state    <= S_PASS2;
              end else begin
                res_status <= mtt_pkg::STATUS_FULL;
              end
            end else if (tail.op == mtt_pkg::OP_FIND || tail.op == mtt_pkg::OP_FORGET) begin
              res_found <= tail.hit;
              if (!tail.hit) res_status <= mtt_pkg::STATUS_MISS;
            end
          end
        end
        S_PASS2: begin
          if (tail.valid) begin
            vis_count <= mtt_pkg::sat_inc(vis_count);
            res_count <= tail.count;
            state     <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            found           <= res_found;
            visible_now     <= res_vis;
            frames_unseen   <= res_unseen;
            frames_followed <= res_followed;
            visible_total   <= vis_count;
            entry_count     <= res_count;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a token leaves the row only while a pass is running
  a_tail_in_pass: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == S_PASS1 || state == S_PASS2))
    else $error("token left the cell row outside a pass");

  // a dropped detection only happens on a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mtt_pkg::STATUS_FULL) |->
      (entry_count == mtt_pkg::CNT_W'(mtt_pkg::MAX_MARKERS)))
    else $error("full status with free entries");

  // a hit never reports an error status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == mtt_pkg::STATUS_OK))
    else $error("found with error status");

  // entry count stays within the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count <= mtt_pkg::CNT_W'(mtt_pkg::MAX_MARKERS)))
    else $error("entry count beyond table size");

endmodule

// ===== design/mtt_cell.sv =====
module mtt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mtt_pkg::CTR_W-1:0]   lost_tol,
  input  logic                        persist,
  input  mtt_pkg::token_t             tok_in,
  output mtt_pkg::token_t             tok_out
);

  // entry storage
  logic                       valid;
  logic [mtt_pkg::ID_W-1:0]   key;
  logic [mtt_pkg::CTR_W-1:0]  unseen;
  logic [mtt_pkg::CTR_W-1:0]  followed;
  logic                       seen;

  logic                       valid_next;
  logic [mtt_pkg::ID_W-1:0]   key_next;
  logic [mtt_pkg::CTR_W-1:0]  unseen_next;
  logic [mtt_pkg::CTR_W-1:0]  followed_next;
  logic                       seen_next;
  mtt_pkg::token_t            tok_next;
  logic                       match;

  assign match = valid && (key == tok_in.id);

  // apply the token's operation to this entry
  always_comb begin
    valid_next    = valid;
    key_next      = key;
    unseen_next   = unseen;
    followed_next = followed;
    seen_next     = seen;
    tok_next      = tok_in;
    if (tok_in.valid) begin
      case (tok_in.op)
        mtt_pkg::OP_BEGIN: begin
          if (valid) begin
            seen_next   = 1'b0;
            unseen_next = mtt_pkg::sat_inc(unseen);
          end
        end
        mtt_pkg::OP_DETECT: begin
          if (!valid) tok_next.free_seen = 1'b1;
          if (match) begin
            unseen_next   = '0;
            seen_next     = 1'b1;
            followed_next = mtt_pkg::sat_inc(followed);
            tok_next.hit  = 1'b1;
          end
        end
        mtt_pkg::OP_END: begin
          if (!persist && valid && (unseen > lost_tol)) valid_next = 1'b0;
        end
        mtt_pkg::OP_FIND: begin
          if (match) begin
            tok_next.hit      = 1'b1;
            tok_next.vis      = seen;
            tok_next.unseen   = unseen;
            tok_next.followed = followed;
          end
        end
        mtt_pkg::OP_FORGET: begin
          if (match) begin
            valid_next   = 1'b0;
            tok_next.hit = 1'b1;
          end
        end
        mtt_pkg::OP_CLEAR: valid_next = 1'b0;
        mtt_pkg::OP_INSERT: begin
          // lowest empty cell takes the new id
          if (!valid && !tok_in.done) begin
            valid_next    = 1'b1;
            key_next      = tok_in.id;
            unseen_next   = '0;
            followed_next = {{(mtt_pkg::CTR_W-1){1'b0}}, 1'b1};
            seen_next     = 1'b1;
            tok_next.done = 1'b1;
          end
        end
        default: ;
      endcase
      tok_next.count = tok_in.count + {{(mtt_pkg::CNT_W-1){1'b0}}, valid_next};
    end
  end

  // entry registers: only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    key      <= key_next;
    unseen   <= unseen_next;
    followed <= followed_next;
    seen     <= seen_next;
  end

  // token stage to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== tb/marker_track_table_tb.sv =====
`timescale 1ns / 100ps

module marker_track_table_tb;

  // commands outside the defined set; the block must leave its state alone
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int POOL_SIZE      = 24;
  localparam int PHASE_ITEMS    = 205;
  localparam int NUM_PHASES     = 7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 2 * mtt_pkg::MAX_MARKERS + 8;

  typedef struct packed {
    logic [1:0]                status;
    logic                      found;
    logic                      vis;
    logic [mtt_pkg::CTR_W-1:0] unseen;
    logic [mtt_pkg::CTR_W-1:0] followed;
    logic [mtt_pkg::CTR_W-1:0] total;
    logic [mtt_pkg::CNT_W-1:0] count;
  } track_result_t;

  // Shadow of the marker table; predicts one result per accepted item
  class track_scoreboard;
    logic [mtt_pkg::CTR_W-1:0] tol;
    logic                      persist;
    bit                        used     [mtt_pkg::MAX_MARKERS];
    logic [mtt_pkg::ID_W-1:0]  key      [mtt_pkg::MAX_MARKERS];
    logic [mtt_pkg::CTR_W-1:0] unseen   [mtt_pkg::MAX_MARKERS];
    logic [mtt_pkg::CTR_W-1:0] followed [mtt_pkg::MAX_MARKERS];
    bit                        seen     [mtt_pkg::MAX_MARKERS];
    logic [mtt_pkg::CTR_W-1:0] vis_count;
    track_result_t             expected_q[$];
    int errors, checked, n_full, n_hit, n_evict;

    function void reset_state();
      tol       = mtt_pkg::LOST_TOL_RESET;
      persist   = 1'b0;
      vis_count = '0;
      foreach (used[i]) used[i] = 1'b0;
      expected_q.delete();
    endfunction

    function void set_reg(logic [mtt_pkg::CFG_IDX_W-1:0] idx,
                          logic [mtt_pkg::CFG_DATA_W-1:0] data);
      if (idx == mtt_pkg::REG_LOST_TOL) tol = data;
      else if (idx == mtt_pkg::REG_PERSIST) persist = data[0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [mtt_pkg::CTR_W-1:0] bump(logic [mtt_pkg::CTR_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function int lookup(logic [mtt_pkg::ID_W-1:0] id);
      int slot;
      slot = -1;
      for (int i = 0; i < mtt_pkg::MAX_MARKERS; i++)
        if (used[i] && key[i] == id && slot < 0) slot = i;
      return slot;
    endfunction

    function void note_item(logic [2:0] cmd, logic [mtt_pkg::ID_W-1:0] id, logic pose);
      track_result_t r;
      int slot;
      int n;
      r = '0;
      case (cmd)
        mtt_pkg::CMD_BEGIN: begin
          for (int i = 0; i < mtt_pkg::MAX_MARKERS; i++)
            if (used[i]) begin
              seen[i]   = 1'b0;
              unseen[i] = bump(unseen[i]);
            end
          vis_count = '0;
        end
        mtt_pkg::CMD_DETECT: begin
          if (pose) begin
            slot = lookup(id);
            if (slot < 0) begin
              // lowest empty slot takes the new id
              for (int i = 0; i < mtt_pkg::MAX_MARKERS; i++)
                if (!used[i] && slot < 0) slot = i;
              if (slot < 0) begin
                r.status = mtt_pkg::STATUS_FULL;
                n_full++;
              end else begin
                used[slot]     = 1'b1;
                key[slot]      = id;
                followed[slot] = '0;
              end
            end
            if (slot >= 0) begin
              unseen[slot]   = '0;
              seen[slot]     = 1'b1;
              followed[slot] = bump(followed[slot]);
              vis_count      = bump(vis_count);
            end
          end
        end
        mtt_pkg::CMD_END: begin
          if (!persist)
            for (int i = 0; i < mtt_pkg::MAX_MARKERS; i++)
              if (used[i] && unseen[i] > tol) begin
                used[i] = 1'b0;
                n_evict++;
              end
        end
        mtt_pkg::CMD_FIND: begin
          slot = lookup(id);
          if (slot < 0) r.status = mtt_pkg::STATUS_MISS;
          else begin
            r.found    = 1'b1;
            r.vis      = seen[slot];
            r.unseen   = unseen[slot];
            r.followed = followed[slot];
            n_hit++;
          end
        end
        mtt_pkg::CMD_FORGET: begin
          slot = lookup(id);
          if (slot < 0) r.status = mtt_pkg::STATUS_MISS;
          else begin
            r.found    = 1'b1;
            used[slot] = 1'b0;
          end
        end
        mtt_pkg::CMD_CLEAR: begin
          foreach (used[i]) used[i] = 1'b0;
        end
        default: ;
      endcase
      n = 0;
      foreach (used[i]) if (used[i]) n++;
      r.total = vis_count;
      r.count = n[mtt_pkg::CNT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(track_result_t got);
      track_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      compare_field("status",          e.status,   got.status);
      compare_field("found",           e.found,    got.found);
      compare_field("visible_now",     e.vis,      got.vis);
      compare_field("frames_unseen",   e.unseen,   got.unseen);
      compare_field("frames_followed", e.followed, got.followed);
      compare_field("visible_total",   e.total,    got.total);
      compare_field("entry_count",     e.count,    got.count);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [mtt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mtt_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [2:0]                     command;
  logic [mtt_pkg::ID_W-1:0]       marker_id;
  logic                           pose_ok;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     status;
  logic                           found;
  logic                           visible_now;
  logic [mtt_pkg::CTR_W-1:0]      frames_unseen;
  logic [mtt_pkg::CTR_W-1:0]      frames_followed;
  logic [mtt_pkg::CTR_W-1:0]      visible_total;
  logic [mtt_pkg::CNT_W-1:0]      entry_count;

  track_scoreboard sb = new;
  logic [mtt_pkg::ID_W-1:0] id_pool [POOL_SIZE];
  int burst_left  = 0;
  int items_sent  = 0;
  int quiet_cycles = 0;

  int unsigned phase_tol [NUM_PHASES] = '{0, 65535, 3, 2, 65535, 1, 30};
  bit          phase_pers[NUM_PHASES] = '{0, 0, 0, 1, 1, 0, 0};

  marker_track_table DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stall pattern: free-running, random, heavy and periodic stretches
  int stall_mode = 0;
  int stall_run  = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    stall_tick++;
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(20, 200);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_tick % 5) < 2);
    endcase
  end

  // monitor: note accepted items, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_item(command, marker_id, pose_ok);
      if (out_valid && !out_stall)
        sb.check_result(track_result_t'({status, found, visible_now, frames_unseen,
                                         frames_followed, visible_total, entry_count}));
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [mtt_pkg::ID_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return mtt_pkg::ID_W'($urandom);
  endfunction

  // one item on the input channel, with bursts and gaps from the sender
  task automatic send_cmd(input logic [2:0] cmd, input logic [mtt_pkg::ID_W-1:0] id,
                          input logic pose);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    command   <= cmd;
    marker_id <= id;
    pose_ok   <= pose;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // drain all outstanding results so the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [mtt_pkg::CTR_W-1:0] tol, input logic pers);
    logic [mtt_pkg::CFG_DATA_W-1:0] pers_word;
    pers_word = {15'($urandom), pers};
    cfg_we    <= 1'b1;
    cfg_index <= mtt_pkg::REG_LOST_TOL;
    cfg_data  <= tol;
    @(posedge clk);
    cfg_index <= mtt_pkg::REG_PERSIST;
    cfg_data  <= pers_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(mtt_pkg::REG_LOST_TOL, tol);
    sb.set_reg(mtt_pkg::REG_PERSIST, pers_word);
  endtask

  // a frame: begin, detections mixed with lookups, end; sometimes broken
  task automatic run_frame();
    int n;
    int r;
    if ($urandom_range(0, 9) != 0) send_cmd(mtt_pkg::CMD_BEGIN, pick_id(), 1'($urandom));
    n = $urandom_range(0, 9);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_cmd(mtt_pkg::CMD_DETECT, pick_id(), $urandom_range(0, 9) != 0);
      else if (r < 92) send_cmd(mtt_pkg::CMD_FIND, pick_id(), 1'($urandom));
      else send_cmd(mtt_pkg::CMD_FORGET, pick_id(), 1'($urandom));
    end
    if ($urandom_range(0, 9) != 0) send_cmd(mtt_pkg::CMD_END, pick_id(), 1'($urandom));
    repeat ($urandom_range(0, 2)) send_cmd(mtt_pkg::CMD_FIND, pick_id(), 1'($urandom));
  endtask

  initial begin
    int phase_start;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    command   = mtt_pkg::CMD_BEGIN;
    marker_id = '0;
    pose_ok   = 1'b0;
    out_stall = 1'b0;
    sb.reset_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, id extremes, repeats, spare commands, forget all
    send_cmd(mtt_pkg::CMD_FIND,   16'h1234, 1'b0);
    send_cmd(mtt_pkg::CMD_FORGET, 16'h1234, 1'b1);
    send_cmd(mtt_pkg::CMD_DETECT, 16'h0000, 1'b0);
    send_cmd(mtt_pkg::CMD_DETECT, 16'h0000, 1'b1);
    send_cmd(mtt_pkg::CMD_DETECT, 16'hFFFF, 1'b1);
    send_cmd(mtt_pkg::CMD_DETECT, 16'h0000, 1'b1);
    send_cmd(mtt_pkg::CMD_FIND,   16'h0000, 1'b0);
    send_cmd(mtt_pkg::CMD_BEGIN,  16'hFFFF, 1'b1);
    send_cmd(mtt_pkg::CMD_FIND,   16'h0000, 1'b1);
    send_cmd(mtt_pkg::CMD_FIND,   16'hFFFF, 1'b0);
    send_cmd(mtt_pkg::CMD_DETECT, 16'h0000, 1'b1);
    send_cmd(CMD_SPARE_LO,        16'hFFFF, 1'b1);
    send_cmd(CMD_SPARE_HI,        16'h0000, 1'b0);
    send_cmd(mtt_pkg::CMD_END,    16'h5A5A, 1'b0);
    send_cmd(mtt_pkg::CMD_FORGET, 16'hFFFF, 1'b0);
    send_cmd(mtt_pkg::CMD_FIND,   16'hFFFF, 1'b1);
    send_cmd(mtt_pkg::CMD_CLEAR,  16'hA5A5, 1'b1);
    send_cmd(mtt_pkg::CMD_FIND,   16'h0000, 1'b0);

    // random phases, one register setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_config(phase_tol[p][mtt_pkg::CTR_W-1:0], phase_pers[p]);
      foreach (id_pool[i]) id_pool[i] = mtt_pkg::ID_W'($urandom);
      phase_start = items_sent;
      while (items_sent < phase_start + PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) run_frame();
        else
          repeat ($urandom_range(1, 3))
            send_cmd(3'($urandom_range(0, 7)), pick_id(), 1'($urandom));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items over %0d register settings; %0d results checked.",
             items_sent, NUM_PHASES, sb.checked);
    $display("Table-full drops %0d, find hits %0d, evictions %0d, mismatches %0d.",
             sb.n_full, sb.n_hit, sb.n_evict, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
